// ===== src/circular_linked_queue_manager_defines.svh =====
// ----------------------------------------------------------------------------
// circular_linked_queue_manager_defines.svh
// Assertion macros used by the queue manager RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LINKED_QUEUE_MANAGER_DEFINES_SVH
`define CIRCULAR_LINKED_QUEUE_MANAGER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CLQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("queue manager check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CLQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue manager check failed");

`endif

// ===== src/clq_pkg.sv =====
// ----------------------------------------------------------------------------
// clq_pkg
// Field widths, request action codes and status codes of the queue manager.
// ----------------------------------------------------------------------------
package clq_pkg;

    // Port field widths
    localparam int ACTION_W = 2;
    localparam int QID_W    = 2;
    localparam int NODE_W   = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    // Result status
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_LINKED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_IN = 2'd3;

endpackage

// ===== src/clq_ram.sv =====
// ----------------------------------------------------------------------------
// clq_ram
// Generic single write port, single read port RAM with registered read data.
// A read of the word being written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module clq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read word; pass the write data through on a match
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/circular_linked_queue_manager.sv =====
// ----------------------------------------------------------------------------
// circular_linked_queue_manager
// Pool of nodes linked into several circular doubly linked queues.
// ----------------------------------------------------------------------------
// Usage:
//   A request (action, queue_id, node) is taken at a rising edge with start
//   high and busy low. Actions: append node at the queue tail, remove node
//   from the queue, query. Other action codes act as a query.
//   Exactly one result per request: done is high for one cycle with status,
//   queue_count, head_node, head_present, node_next, node_prev, node_linked.
//   The receiver cannot stall; the result must be taken in that cycle.
// Timing:
//   At the accept edge the node's tag and link words are read from the pool
//   RAMs; they are used in the execute state and updated at its end. done
//   rises after the execute state, and a new request may be accepted in that
//   same cycle, so a request is not taken while the last one executes.
// Reset:
//   After reset the block sweeps the node tag RAM clear, one entry a cycle,
//   with busy high until every entry is written. All queues start empty.
//   The tail's successor and the head's predecessor live in the per-queue
//   registers, so each request writes at most one word per link RAM.
// ----------------------------------------------------------------------------
`include "circular_linked_queue_manager_defines.svh"

module circular_linked_queue_manager #(
    parameter int POOL_NODES  = 64,
    parameter int QUEUE_COUNT = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [clq_pkg::ACTION_W-1:0]  action,
    input  logic [clq_pkg::QID_W-1:0]     queue_id,
    input  logic [clq_pkg::NODE_W-1:0]    node,
    output logic                          busy,
    output logic                          done,
    output logic [clq_pkg::STATUS_W-1:0]  status,
    output logic [clq_pkg::COUNT_W-1:0]   queue_count,
    output logic [clq_pkg::NODE_W-1:0]    head_node,
    output logic                          head_present,
    output logic [clq_pkg::NODE_W-1:0]    node_next,
    output logic [clq_pkg::NODE_W-1:0]    node_prev,
    output logic                          node_linked
);

    localparam int IDX_W      = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int Q_W        = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int CNT_W      = $clog2(POOL_NODES + 1);
    localparam int TAG_W      = Q_W + 1;
    localparam int NODE_CODES = 2 ** clq_pkg::NODE_W;
    localparam int QID_CODES  = 2 ** clq_pkg::QID_W;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_CLEAR = 2'd0;
    localparam logic [ST_W-1:0] ST_IDLE  = 2'd1;
    localparam logic [ST_W-1:0] ST_EXEC  = 2'd2;

    logic [ST_W-1:0]  state_reg, state_next;
    logic [IDX_W-1:0] clr_reg;
    logic             accept;

    // Request register
    logic [clq_pkg::ACTION_W-1:0] act_reg;
    logic [Q_W-1:0]               q_reg;
    logic [IDX_W-1:0]             n_reg;

    // Per-queue state
    logic [IDX_W-1:0]       qhead_reg  [QUEUE_COUNT];
    logic [IDX_W-1:0]       qtail_reg  [QUEUE_COUNT];
    logic [CNT_W-1:0]       qcount_reg [QUEUE_COUNT];
    logic [QUEUE_COUNT-1:0] qvalid_reg;

    // Index wrap tables
    logic [IDX_W-1:0] node_wrap [NODE_CODES];
    logic [Q_W-1:0]   qid_wrap  [QID_CODES];
    logic [IDX_W-1:0] in_n;
    logic [Q_W-1:0]   in_q;

    // RAM ports
    logic             tag_we, next_we, prev_we;
    logic [IDX_W-1:0] tag_waddr, next_waddr, prev_waddr;
    logic [TAG_W-1:0] tag_wdata, tag_rd;
    logic [IDX_W-1:0] next_wdata, prev_wdata, next_rd, prev_rd;

    // Execute-stage signals
    logic                         rd_linked;
    logic [Q_W-1:0]               rd_owner;
    logic [IDX_W-1:0]             cur_head, cur_tail, own_head, own_tail;
    logic [CNT_W-1:0]             cur_cnt;
    logic                         cur_valid;
    logic [IDX_W-1:0]             eff_next, eff_prev;
    logic                         do_app, do_rem, only_one;
    logic [clq_pkg::STATUS_W-1:0] st_val;
    logic [IDX_W-1:0]             new_head, new_tail;
    logic [CNT_W-1:0]             new_cnt;
    logic                         new_valid;
    logic                         res_linked;
    logic [IDX_W-1:0]             res_next, res_prev;

    // Result register
    logic                         done_reg;
    logic [clq_pkg::STATUS_W-1:0] status_reg;
    logic [clq_pkg::COUNT_W-1:0]  count_reg;
    logic [clq_pkg::NODE_W-1:0]   head_reg;
    logic                         present_reg;
    logic [clq_pkg::NODE_W-1:0]   next_reg;
    logic [clq_pkg::NODE_W-1:0]   prev_reg;
    logic                         linked_reg;

    // Build wrap tables for out-of-range node and queue indices
    for (genvar gi = 0; gi < NODE_CODES; gi++)
    begin : g_node_wrap
        assign node_wrap[gi] = IDX_W'(gi % POOL_NODES);
    end

    for (genvar gq = 0; gq < QID_CODES; gq++)
    begin : g_qid_wrap
        assign qid_wrap[gq] = Q_W'(gq % QUEUE_COUNT);
    end

    assign in_n   = node_wrap[node];
    assign in_q   = qid_wrap[queue_id];
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Sequence: clear sweep, then idle/execute per request
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == IDX_W'(POOL_NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            q_reg   <= in_q;
            n_reg   <= in_n;
        end
    end

    // Node tag RAM: linked flag over owner queue
    clq_ram #(
        .WIDTH (TAG_W),
        .DEPTH (POOL_NODES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (accept),
        .raddr (in_n),
        .rdata (tag_rd)
    );

    // Successor link RAM
    clq_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_NODES)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (accept),
        .raddr (in_n),
        .rdata (next_rd)
    );

    // Predecessor link RAM
    clq_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_NODES)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (accept),
        .raddr (in_n),
        .rdata (prev_rd)
    );

    // Look up node and queue state; tail-to-head wrap comes from the queue registers
    assign rd_linked = tag_rd[Q_W];
    assign rd_owner  = tag_rd[Q_W-1:0];
    assign cur_head  = qhead_reg[q_reg];
    assign cur_tail  = qtail_reg[q_reg];
    assign cur_cnt   = qcount_reg[q_reg];
    assign cur_valid = qvalid_reg[q_reg];
    assign own_head  = qhead_reg[rd_owner];
    assign own_tail  = qtail_reg[rd_owner];
    assign eff_next  = (n_reg == own_tail) ? own_head : next_rd;
    assign eff_prev  = (n_reg == own_head) ? own_tail : prev_rd;
    assign only_one  = (cur_head == cur_tail);

    // Decide the action and its status
    always_comb
    begin
        st_val = clq_pkg::STAT_OK;
        do_app = 1'b0;
        do_rem = 1'b0;
        if (state_reg == ST_EXEC)
        begin
            unique case (act_reg)
                clq_pkg::ACT_APPEND:
                begin
                    if (rd_linked)
                    begin
                        st_val = clq_pkg::STAT_LINKED;
                    end
                    else
                    begin
                        do_app = 1'b1;
                    end
                end
                clq_pkg::ACT_REMOVE:
                begin
                    if (!cur_valid)
                    begin
                        st_val = clq_pkg::STAT_EMPTY;
                    end
                    else if (!rd_linked || (rd_owner != q_reg))
                    begin
                        st_val = clq_pkg::STAT_NOT_IN;
                    end
                    else
                    begin
                        do_rem = 1'b1;
                    end
                end
                default:
                begin
                    st_val = clq_pkg::STAT_OK;
                end
            endcase
        end
    end

    // Compute the addressed queue after the step
    always_comb
    begin
        new_head  = cur_head;
        new_tail  = cur_tail;
        new_cnt   = cur_cnt;
        new_valid = cur_valid;
        if (do_app)
        begin
            new_valid = 1'b1;
            new_head  = cur_valid ? cur_head : n_reg;
            new_tail  = n_reg;
            new_cnt   = cur_cnt + CNT_W'(1);
        end
        else if (do_rem)
        begin
            new_cnt = (cur_cnt != '0) ? (cur_cnt - CNT_W'(1)) : cur_cnt;
            if (only_one)
            begin
                new_valid = 1'b0;
            end
            else
            begin
                new_head = (n_reg == cur_head) ? eff_next : cur_head;
                new_tail = (n_reg == cur_tail) ? eff_prev : cur_tail;
            end
        end
    end

    // Drive link and tag writes
    always_comb
    begin
        next_we    = 1'b0;
        next_waddr = eff_prev;
        next_wdata = eff_next;
        prev_we    = 1'b0;
        prev_waddr = eff_next;
        prev_wdata = eff_prev;
        if (do_app)
        begin
            next_we    = cur_valid;
            next_waddr = cur_tail;
            next_wdata = n_reg;
            prev_we    = cur_valid;
            prev_waddr = n_reg;
            prev_wdata = cur_tail;
        end
        else if (do_rem)
        begin
            next_we = !only_one;
            prev_we = !only_one;
        end
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            tag_we    = 1'b1;
            tag_waddr = clr_reg;
            tag_wdata = '0;
        end
        else
        begin
            tag_we    = do_app || do_rem;
            tag_waddr = n_reg;
            tag_wdata = do_app ? {1'b1, q_reg} : '0;
        end
    end

    // Report the node after the step
    always_comb
    begin
        res_linked = rd_linked;
        res_next   = eff_next;
        res_prev   = eff_prev;
        if (do_app)
        begin
            res_linked = 1'b1;
            res_next   = cur_valid ? cur_head : n_reg;
            res_prev   = cur_valid ? cur_tail : n_reg;
        end
        else if (do_rem)
        begin
            res_linked = 1'b0;
        end
    end

    // Update per-queue control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qvalid_reg <= '0;
            for (int i = 0; i < QUEUE_COUNT; i++)
            begin
                qcount_reg[i] <= '0;
            end
        end
        else if (do_app || do_rem)
        begin
            qvalid_reg[q_reg] <= new_valid;
            qcount_reg[q_reg] <= new_cnt;
        end
    end

    // Update per-queue head and tail
    always_ff @(posedge clk)
    begin
        if (do_app || do_rem)
        begin
            qhead_reg[q_reg] <= new_head;
            qtail_reg[q_reg] <= new_tail;
        end
    end

    // Register the result; done is high for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            status_reg  <= st_val;
            count_reg   <= clq_pkg::COUNT_W'(new_cnt);
            head_reg    <= new_valid ? clq_pkg::NODE_W'(new_head) : '0;
            present_reg <= new_valid;
            next_reg    <= res_linked ? clq_pkg::NODE_W'(res_next) : '0;
            prev_reg    <= res_linked ? clq_pkg::NODE_W'(res_prev) : '0;
            linked_reg  <= res_linked;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign queue_count  = count_reg;
    assign head_node    = head_reg;
    assign head_present = present_reg;
    assign node_next    = next_reg;
    assign node_prev    = prev_reg;
    assign node_linked  = linked_reg;

    // Checks
    `CLQ_ASSERT_NEXT(a_accept_exec, accept, state_reg == ST_EXEC)
    `CLQ_ASSERT_NEXT(a_exec_done, state_reg == ST_EXEC, done && !busy)
    `CLQ_ASSERT_NOW(a_clear_quiet, state_reg == ST_CLEAR, !done && tag_we)
    `CLQ_ASSERT_NOW(a_valid_count, state_reg == ST_EXEC, cur_valid == (cur_cnt != '0))

endmodule
